// ----- design/mtdl_pkg.sv -----
// Shared types and constants for the multi-tap delay line.
// No dependencies; imported by every module of the block except mtdl_ram.
package mtdl_pkg;

	localparam int SAMPLE_W = 24;
	localparam int DELAY_W  = 15;
	localparam int GAIN_W   = 16;
	localparam int LEN_W    = 16;
	localparam int FRAC_W   = 14;
	localparam int QDEPTH   = 2;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 24;

	localparam logic [1:0] CMD_SAMPLE   = 2'd0;
	localparam logic [1:0] CMD_ADD_TAP  = 2'd1;
	localparam logic [1:0] CMD_CLR_TAPS = 2'd2;
	localparam logic [1:0] CMD_CLR_MEM  = 2'd3;

	typedef struct packed {
		logic smp;
		logic add;
		logic clr_taps;
		logic clr_mem;
	} cls_t;

	typedef struct packed {
		cls_t                       cls;
		logic signed [SAMPLE_W-1:0] sample;
		logic [DELAY_W-1:0]         delay;
		logic signed [GAIN_W-1:0]   gain;
	} q_item_t;

	typedef struct packed {
		logic pop;
		logic init_done;
	} bk_ctl_t;

endpackage

// ----- design/mtdl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module mtdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/mtdl_front.sv -----
// Front end: accepts stream items, decodes the command and queues them for the back end.
// Depends on mtdl_pkg.
module mtdl_front import mtdl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  logic [1:0]            s_axis_tuser,
	input  bk_ctl_t               ctl,
	output logic                  q_valid,
	output q_item_t               q_item
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNTW = $clog2(QDEPTH + 1);

	q_item_t          fifo_q [QDEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	q_item_t          item_in;
	logic             push;
	logic             pop;

	always_comb begin
		item_in.cls    = '0;
		item_in.sample = s_axis_tdata[23:0];
		item_in.delay  = s_axis_tdata[38:24];
		item_in.gain   = s_axis_tdata[54:39];
		unique case (s_axis_tuser)
			CMD_SAMPLE:   item_in.cls.smp      = 1'b1;
			CMD_ADD_TAP:  item_in.cls.add      = 1'b1;
			CMD_CLR_TAPS: item_in.cls.clr_taps = 1'b1;
			CMD_CLR_MEM:  item_in.cls.clr_mem  = 1'b1;
		endcase
	end

	assign s_axis_tready = ctl.init_done && (cnt_q != CNTW'(QDEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (cnt_q != '0);
	assign pop           = ctl.pop && q_valid;
	assign q_item        = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/mtdl_back.sv -----
// Back end: delay memory, tap table, tap multiply-accumulate sequencer and result register.
// Depends on mtdl_pkg and mtdl_ram.
module mtdl_back import mtdl_pkg::*; #(
	parameter int DELAY_DEPTH = 32768,
	parameter int MAX_TAPS    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [LEN_W-1:0]    cfg_wdata,
	input  logic                q_valid,
	input  q_item_t             q_item,
	output bk_ctl_t             ctl,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [SAMPLE_W-1:0] res_sample,
	output logic                res_status
);

	localparam int AW     = $clog2(DELAY_DEPTH);
	localparam int LW     = $clog2(DELAY_DEPTH + 1);
	localparam int DW     = (AW > DELAY_W) ? AW : DELAY_W;
	localparam int IW     = DW + 2;
	localparam int CW     = $clog2(MAX_TAPS + 1);
	localparam int TW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int PROD_W = SAMPLE_W + GAIN_W;
	localparam int ACC_W  = PROD_W + CW;
	localparam int LEN_RST = (DELAY_DEPTH < 32768) ? DELAY_DEPTH : 32768;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX  = (ACC_W'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam logic signed [ACC_W-1:0] SAT_MIN  = -(ACC_W'(1) <<< (SAMPLE_W - 1));

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_TAPS  = 3'd2;
	localparam logic [2:0] ST_DONE  = 3'd3;

	logic [2:0]                 state_q;
	logic                       init_q;
	logic [AW-1:0]              clr_q;
	logic [LW-1:0]              len_q;
	logic [AW-1:0]              wp_q;
	logic [CW-1:0]              tap_count_q;
	logic [CW-1:0]              k_q;
	logic [DELAY_W-1:0]         tap_delay_q [MAX_TAPS];
	logic signed [GAIN_W-1:0]   tap_gain_q  [MAX_TAPS];
	logic signed [ACC_W-1:0]    acc_q;
	logic [SAMPLE_W-1:0]        res_sample_q;
	logic                       res_status_q;
	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        out_sample_q;
	logic                       out_status_q;

	logic                       v_s1;
	logic signed [GAIN_W-1:0]   gain_s1;
	logic                       v_s2;
	logic signed [PROD_W-1:0]   prod_s2;

	logic                       pop;
	logic [AW-1:0]              wp_use;
	logic [AW-1:0]              wp_next;
	logic                       issuing;
	logic                       finish;
	logic [TW-1:0]              k_idx;
	logic [IW-1:0]              diff;
	logic [IW-1:0]              wrap;
	logic [IW-1:0]              idx_sel;
	logic                       hit;
	logic                       add_reject;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [SAMPLE_W-1:0]        ram_wdata;
	logic [SAMPLE_W-1:0]        ram_rdata;
	logic signed [ACC_W-1:0]    rnd;
	logic signed [ACC_W-1:0]    shf;
	logic [SAMPLE_W-1:0]        sat;
	logic                       out_load;

	assign pop    = (state_q == ST_IDLE) && q_valid;
	assign ctl.pop       = pop;
	assign ctl.init_done = !init_q;

	assign wp_use  = (LW'(wp_q) >= len_q) ? '0 : wp_q;
	assign wp_next = ((LW'(wp_q) + 1'b1) >= len_q) ? '0 : wp_q + 1'b1;

	assign issuing = (state_q == ST_TAPS) && (k_q < tap_count_q);
	assign finish  = (state_q == ST_TAPS) && !issuing && !v_s1 && !v_s2;
	assign k_idx   = k_q[TW-1:0];
	assign diff    = IW'(wp_q) - IW'(tap_delay_q[k_idx]);
	assign wrap    = diff + IW'(len_q);
	assign idx_sel = diff[IW-1] ? wrap : diff;
	assign hit     = !idx_sel[IW-1];

	assign add_reject = ((DW + 1)'(q_item.delay) >= (DW + 1)'(len_q)) ||
	                    (tap_count_q == CW'(MAX_TAPS));

	assign ram_we    = (state_q == ST_CLEAR) || (pop && q_item.cls.smp);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : wp_use;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : q_item.sample;

	mtdl_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DELAY_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issuing),
		.raddr (idx_sel[AW-1:0]),
		.rdata (ram_rdata)
	);

	// round half up, then saturate
	always_comb begin
		rnd = acc_q + RND_HALF;
		shf = rnd >>> FRAC_W;
		priority if (shf > SAT_MAX) begin
			sat = SAT_MAX[SAMPLE_W-1:0];
		end else if (shf < SAT_MIN) begin
			sat = SAT_MIN[SAMPLE_W-1:0];
		end else begin
			sat = shf[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		gain_s1 <= tap_gain_q[k_idx];
		prod_s2 <= signed'(ram_rdata) * gain_s1;
		if (pop && q_item.cls.add && !add_reject) begin
			tap_delay_q[tap_count_q[TW-1:0]] <= q_item.delay;
			tap_gain_q[tap_count_q[TW-1:0]]  <= q_item.gain;
		end
		if (pop) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (out_load) begin
			out_sample_q <= res_sample_q;
			out_status_q <= res_status_q;
		end
		if (finish) begin
			res_sample_q <= sat;
			res_status_q <= 1'b0;
		end else if (pop) begin
			res_sample_q <= '0;
			res_status_q <= q_item.cls.add && add_reject;
		end else if (state_q == ST_CLEAR) begin
			res_sample_q <= '0;
			res_status_q <= 1'b0;
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			init_q      <= 1'b1;
			clr_q       <= '0;
			len_q       <= LW'(LEN_RST);
			wp_q        <= '0;
			tap_count_q <= '0;
			k_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issuing && hit;
			v_s2 <= v_s1;
			if (cfg_we) begin
				if (cfg_wdata == '0) begin
					len_q <= LW'(1);
				end else if (32'(cfg_wdata) > DELAY_DEPTH) begin
					len_q <= LW'(DELAY_DEPTH);
				end else begin
					len_q <= LW'(cfg_wdata);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						clr_q   <= '0;
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_DONE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						priority if (q_item.cls.smp) begin
							wp_q    <= wp_use;
							k_q     <= '0;
							state_q <= ST_TAPS;
						end else if (q_item.cls.add) begin
							if (!add_reject) begin
								tap_count_q <= tap_count_q + 1'b1;
							end
							state_q <= ST_DONE;
						end else if (q_item.cls.clr_taps) begin
							tap_count_q <= '0;
							state_q     <= ST_DONE;
						end else begin
							wp_q    <= '0;
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_TAPS: begin
					if (issuing) begin
						k_q <= k_q + 1'b1;
					end
					if (finish) begin
						wp_q    <= wp_next;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid  = out_valid_q;
	assign res_sample = out_sample_q;
	assign res_status = out_status_q;

endmodule

// ----- design/multi_tap_delay_line_top.sv -----
// Multi-tap delay line top level: stream ports, config port, front and back ends.
// Depends on mtdl_pkg, mtdl_front, mtdl_back (and mtdl_ram through the back end).
//
//   port group   dir   tdata fields (low bit up)                         tuser
//   s_axis       in    sample_in[23:0] tap_delay[38:24] tap_gain[54:39]  command[1:0]
//   m_axis       out   sample_out[23:0]                                  status[0]
//   cfg          in    cfg_wdata = line_length[15:0], taken when cfg_we  -
//
// Sample item: one tap read and multiply-accumulate per cycle on the single
// delay-memory read port. Tap add and clear taps go from idle straight to the
// result register.
// Clear delay memory: one memory word zeroed per cycle.
// After reset the memory is zeroed with s_axis_tready low.
// A two-entry queue accepts items until full while the back end works or m_axis stalls.
module multi_tap_delay_line_top import mtdl_pkg::*; #(
	parameter int DELAY_DEPTH = 32768,
	parameter int MAX_TAPS    = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample_in, tap_delay, tap_gain, pad
	input  logic [1:0]             s_axis_tuser,  // command
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // sample_out
	output logic                   m_axis_tuser,  // status
	input  logic                   cfg_we,
	input  logic [LEN_W-1:0]       cfg_wdata
);

	bk_ctl_t ctl;
	logic    q_valid;
	q_item_t q_item;

	mtdl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.ctl           (ctl),
		.q_valid       (q_valid),
		.q_item        (q_item)
	);

	mtdl_back #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.MAX_TAPS    (MAX_TAPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.ctl        (ctl),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_sample (m_axis_tdata),
		.res_status (m_axis_tuser)
	);

endmodule

// ----- dv/tb_multi_tap_delay_line_top.sv -----
`timescale 1ns / 100ps

// Testbench for multi_tap_delay_line_top: directed and random items on s_axis, results on
// m_axis checked against a tap-sum predictor kept in a small scoreboard class.
// Depends on mtdl_pkg and the block's RTL.
module tb_multi_tap_delay_line_top import mtdl_pkg::*;;

	localparam int DEPTH          = 32768;
	localparam int NTAPS          = 16;
	localparam int RANDOM_ITEMS   = 400;
	localparam int CYCLE_LIMIT    = 1500000;
	localparam int MAX_MEM_CLEARS = 3;
	localparam int MAX_REPORTS    = 10;
	localparam longint SAT_HI     = 64'sd8388607;
	localparam longint SAT_LO     = -64'sd8388608;
	localparam longint HALF_LSB   = 64'sd1 << (FRAC_W - 1);

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       status;
	} tap_out_t;

	class delay_line_scoreboard;
		int               mem[DEPTH];
		int               wr_pos;
		int               tap_dly[NTAPS];
		int               tap_gain[NTAPS];
		int               n_taps;
		logic [LEN_W-1:0] line_len;
		tap_out_t         pending_outputs[$];
		int               mismatches;

		function new();
			foreach (mem[i]) mem[i] = 0;
			wr_pos = 0;
			n_taps = 0;
			line_len = 16'h8000;
			mismatches = 0;
		endfunction

		function int active_len();
			if (line_len == 0) return 1;
			if (line_len > DEPTH) return DEPTH;
			return int'(line_len);
		endfunction

		function void take_item(logic [1:0] cmd, logic signed [SAMPLE_W-1:0] smp,
				logic [DELAY_W-1:0] dly, logic signed [GAIN_W-1:0] gn);
			longint   len;
			longint   acc;
			longint   q;
			longint   idx;
			tap_out_t res;
			len = active_len();
			res.sample = '0;
			res.status = 1'b0;
			if (cmd == CMD_SAMPLE) begin
				if (wr_pos >= len) wr_pos = 0;
				mem[wr_pos] = smp;
				acc = 0;
				for (int k = 0; k < n_taps; k++) begin
					idx = wr_pos - tap_dly[k];
					if (idx < 0) idx += len;
					if (idx >= 0 && idx < len) acc += longint'(mem[idx]) * tap_gain[k];
				end
				q = (acc + HALF_LSB) >>> FRAC_W;
				if (q > SAT_HI) q = SAT_HI;
				if (q < SAT_LO) q = SAT_LO;
				res.sample = q[SAMPLE_W-1:0];
				wr_pos = (wr_pos + 1 >= len) ? 0 : wr_pos + 1;
			end else if (cmd == CMD_ADD_TAP) begin
				if (dly >= len || n_taps >= NTAPS) begin
					res.status = 1'b1;
				end else begin
					tap_dly[n_taps] = dly;
					tap_gain[n_taps] = gn;
					n_taps++;
				end
			end else if (cmd == CMD_CLR_TAPS) begin
				n_taps = 0;
			end else begin
				foreach (mem[i]) mem[i] = 0;
				wr_pos = 0;
			end
			pending_outputs.insert(pending_outputs.size(), res);
		endfunction

		function void check_output(logic [SAMPLE_W-1:0] data, logic status);
			tap_out_t want;
			if (pending_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected item: sample_out %0d status %0d",
						$signed(data), status);
				return;
			end
			want = pending_outputs.pop_front();
			if (data !== want.sample || status !== want.status) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch: sample_out exp %0d got %0d, status exp %0d got %0d",
						want.sample, $signed(data), want.status, status);
			end
		endfunction

		function int failures();
			return mismatches + pending_outputs.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;  // sample_in, tap_delay, tap_gain, pad
	logic [1:0]             s_axis_tuser;  // command
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // sample_out
	logic                   m_axis_tuser;  // status
	logic                   cfg_we;
	logic [LEN_W-1:0]       cfg_wdata;

	delay_line_scoreboard sb = new();
	bit                   tx_idle_on = 1'b1;
	bit                   rx_idle_on = 1'b1;
	int                   cycles = 0;

	multi_tap_delay_line_top #(
		.DELAY_DEPTH(DEPTH),
		.MAX_TAPS   (NTAPS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
			sb.check_output(m_axis_tdata, m_axis_tuser);
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap(bit on);
		int r;
		if (!on) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int v;
		if ($urandom_range(0, 4) != 0) v = $urandom;
		else v = int'($urandom_range(0, 2000)) - 1000;
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic [DELAY_W-1:0] rand_delay(int len);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 55) v = $urandom_range(0, (len - 1 < 31) ? len - 1 : 31);
		else if (r < 85) v = $urandom_range(0, len - 1);
		else v = $urandom;
		return v[DELAY_W-1:0];
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain();
		int v;
		if ($urandom_range(0, 9) < 7) v = $urandom;
		else v = int'($urandom_range(0, 32768)) - 16384;
		return v[GAIN_W-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		int v;
		case ($urandom_range(0, 9))
			0: v = 1;
			1: v = $urandom_range(2, 8);
			2: v = $urandom_range(9, 64);
			3: v = $urandom_range(65, 2000);
			4: v = $urandom_range(2001, 32767);
			5: v = 32768;
			6: v = 0;
			7: v = $urandom_range(32769, 65535);
			8: v = 65535;
			default: v = $urandom_range(2, 40);
		endcase
		return v[LEN_W-1:0];
	endfunction

	task automatic send_item(input logic [1:0] cmd, input logic [SAMPLE_W-1:0] smp,
			input logic [DELAY_W-1:0] dly, input logic [GAIN_W-1:0] gn);
		int gap;
		gap = pick_gap(tx_idle_on);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, gn, dly, smp};
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		sb.take_item(cmd, smp, dly, gn);
	endtask

	// hold the sender until every outstanding item has come back
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending_outputs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_line_length(input logic [LEN_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.line_len = v;
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
		send_item(CMD_SAMPLE, smp, rand_delay(DEPTH), rand_gain());
	endtask

	task automatic send_tap(input logic [DELAY_W-1:0] dly, input logic [GAIN_W-1:0] gn);
		send_item(CMD_ADD_TAP, rand_sample(), dly, gn);
	endtask

	initial begin : result_sink
		int stall;
		m_axis_tready <= 1'b0;
		forever begin
			@(negedge clk);
			stall = pick_gap(rx_idle_on);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	initial begin : stimulus
		int random_sent;
		int mem_clears;
		int n;
		int r;
		random_sent = 0;
		mem_clears  = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= CMD_SAMPLE;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		write_line_length(16'h8000);

		send_sample(24'h7FFFFF);
		send_tap(15'd0, 16'h4000);
		send_tap(15'h7FFF, 16'h8000);
		send_tap(15'd1, 16'h7FFF);
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h800000);
		send_item(CMD_CLR_TAPS, rand_sample(), rand_delay(DEPTH), rand_gain());
		// gain of one half: checks round half up on both signs
		send_tap(15'd0, 16'h2000);
		send_sample(24'h000001);
		send_sample(24'hFFFFFF);
		send_sample(24'hFFFFFD);
		send_item(CMD_CLR_MEM, rand_sample(), rand_delay(DEPTH), rand_gain());
		send_tap(15'd3, 16'hC000);
		send_tap(15'd10, 16'h4000);
		repeat (4) send_sample(rand_sample());
		// shorter line: position past the end, stale long taps
		settle();
		write_line_length(16'd2);
		repeat (3) send_sample(rand_sample());
		send_tap(15'd2, rand_gain());
		send_tap(15'd1, rand_gain());
		settle();
		write_line_length(16'd0);
		repeat (2) send_sample(rand_sample());
		settle();
		write_line_length(16'hFFFF);

		while (random_sent < RANDOM_ITEMS) begin
			settle();
			write_line_length(pick_len());
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) == 0) begin
				send_item(CMD_CLR_TAPS, rand_sample(), rand_delay(DEPTH), rand_gain());
				random_sent++;
			end
			n = $urandom_range(0, 18);
			repeat (n) begin
				send_tap(rand_delay(sb.active_len()), rand_gain());
				random_sent++;
			end
			n = $urandom_range(15, 45);
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(0, 99);
				if (r < 6) begin
					send_tap(rand_delay(sb.active_len()), rand_gain());
				end else if (r < 9) begin
					send_item(CMD_CLR_TAPS, rand_sample(), rand_delay(DEPTH), rand_gain());
				end else if (r == 9 && mem_clears < MAX_MEM_CLEARS) begin
					send_item(CMD_CLR_MEM, rand_sample(), rand_delay(DEPTH), rand_gain());
					mem_clears++;
				end else begin
					send_sample(rand_sample());
				end
				random_sent++;
				if (i == n / 2 && $urandom_range(0, 3) == 0) settle();
			end
		end

		settle();
		repeat (100) @(posedge clk);
		if (sb.failures() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
design/mtdl_pkg.sv
design/mtdl_ram.sv
design/mtdl_front.sv
design/mtdl_back.sv
design/multi_tap_delay_line_top.sv
dv/tb_multi_tap_delay_line_top.sv
